// ===== hdl/utf8_to_utf16_decoder_core_macros.svh =====
// assertion macros shared by the utf-8 to utf-16 decoder rtl
// no dependencies; define ASSERT_OFF to drop every check
`ifndef UTF8_TO_UTF16_DECODER_CORE_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// plain property, sampled on the rising edge, off during reset
`define UTF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// overlapping implication
`define UTF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define UTF_ASSERT(lbl, clk, rst_n, prop, msg)
`define UTF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/utfdec_pkg.sv =====
// types and constants of the utf-8 to utf-16 decoder
// used by the front, back and top rtl files of the block; no dependencies
package utfdec_pkg;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       text_end;
	} item_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        unit_valid;
		logic        text_done;
		logic        run_last;
	} result_t;

	// what follows the replacement units of one item
	typedef logic [1:0] tail_t;
	localparam tail_t TAIL_NONE = 2'd0;
	localparam tail_t TAIL_UNIT = 2'd1;
	localparam tail_t TAIL_PAIR = 2'd2;
	localparam tail_t TAIL_END  = 2'd3;

	// descriptor handed from front to back
	typedef struct packed {
		logic [1:0]  n_repl;
		tail_t       tail;
		logic [15:0] unit_a;
		logic [15:0] unit_b;
	} desc_t;

	localparam logic [15:0] REPL_UNIT = 16'hFFFD;
	localparam logic [15:0] HI_SURR   = 16'hD800;
	localparam logic [15:0] LO_SURR   = 16'hDC00;
	localparam logic [20:0] CP_MAX    = 21'h10FFFF;
	localparam logic [20:0] SURR_MIN  = 21'h00D800;
	localparam logic [20:0] SURR_MAX  = 21'h00DFFF;
	localparam logic [20:0] SUPP_BASE = 21'h010000;

endpackage

// ===== hdl/utfdec_fifo.sv =====
// small word queue between the decoder front and back
// depends on utf8_to_utf16_decoder_core_macros.svh
`include "utf8_to_utf16_decoder_core_macros.svh"
module utfdec_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`UTF_ASSERT_IMP(a_fifo_no_underflow, clk, arst_n, rd_en, count_q != '0, "read from empty queue")
	`UTF_ASSERT_IMP(a_fifo_no_overflow, clk, arst_n, wr_en && !rd_en, count_q != FULL_CNT, "write to full queue")

endmodule

// ===== hdl/utfdec_front.sv =====
// decoder front: takes bytes, tracks the open sequence, classifies each item
// depends on utfdec_pkg and utf8_to_utf16_decoder_core_macros.svh
`include "utf8_to_utf16_decoder_core_macros.svh"
module utfdec_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  utfdec_pkg::item_t  item,
	output utfdec_pkg::desc_t  desc,
	output logic               desc_valid
);

	logic [1:0]  exp_q;
	logic [1:0]  seen_q;
	logic [20:0] part_q;

	logic [1:0]  exp_d;
	logic [1:0]  seen_d;
	logic [20:0] part_d;
	logic        is_cont;
	logic        seq_open;
	logic [1:0]  flush_n;
	logic [1:0]  seen_inc;
	logic [20:0] cp;
	logic [20:0] rest;
	logic [7:0]  b;

	assign b        = item.text_byte;
	assign is_cont  = (b[7:6] == 2'b10);
	assign seq_open = (exp_q != 2'd0);
	assign flush_n  = seq_open ? seen_q + 2'd1 : 2'd0;
	assign seen_inc = seen_q + 2'd1;
	assign cp       = {part_q[14:0], b[5:0]};
	assign rest     = cp - utfdec_pkg::SUPP_BASE;

	always_comb begin
		exp_d       = 2'd0;
		seen_d      = 2'd0;
		part_d      = '0;
		desc.n_repl = 2'd0;
		desc.tail   = utfdec_pkg::TAIL_NONE;
		desc.unit_a = utfdec_pkg::REPL_UNIT;
		desc.unit_b = 16'd0;
		if (item.text_end) begin
			desc.n_repl = flush_n;
			desc.tail   = utfdec_pkg::TAIL_END;
			desc.unit_a = 16'd0;
		end else if (seq_open && is_cont) begin
			if (seen_inc >= exp_q) begin
				// sequence complete: range check (replacement unit on failure), then bmp unit or surrogate pair
				if (cp > utfdec_pkg::CP_MAX ||
						(cp >= utfdec_pkg::SURR_MIN && cp <= utfdec_pkg::SURR_MAX)) begin
					desc.tail = utfdec_pkg::TAIL_UNIT;
				end else if (cp >= utfdec_pkg::SUPP_BASE) begin
					desc.tail   = utfdec_pkg::TAIL_PAIR;
					desc.unit_a = utfdec_pkg::HI_SURR + {6'd0, rest[19:10]};
					desc.unit_b = utfdec_pkg::LO_SURR + {6'd0, rest[9:0]};
				end else begin
					desc.tail   = utfdec_pkg::TAIL_UNIT;
					desc.unit_a = cp[15:0];
				end
			end else begin
				exp_d  = exp_q;
				seen_d = seen_inc;
				part_d = cp;
			end
		end else begin
			// broken sequence is flushed, then the byte is taken afresh
			desc.n_repl = flush_n;
			if (!b[7]) begin
				desc.tail   = utfdec_pkg::TAIL_UNIT;
				desc.unit_a = {8'd0, b};
			end else if (b[7:5] == 3'b110) begin
				exp_d  = 2'd1;
				part_d = {16'd0, b[4:0]};
			end else if (b[7:4] == 4'b1110) begin
				exp_d  = 2'd2;
				part_d = {17'd0, b[3:0]};
			end else if (b[7:3] == 5'b11110) begin
				exp_d  = 2'd3;
				part_d = {18'd0, b[2:0]};
			end else begin
				desc.tail = utfdec_pkg::TAIL_UNIT;
			end
		end
	end

	assign desc_valid = (desc.n_repl != 2'd0) || (desc.tail != utfdec_pkg::TAIL_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q  <= 2'd0;
			seen_q <= 2'd0;
			part_q <= '0;
		end else if (take) begin
			exp_q  <= exp_d;
			seen_q <= seen_d;
			part_q <= part_d;
		end
	end

	`UTF_ASSERT_IMP(a_front_idle_clear, clk, arst_n, exp_q == 2'd0, seen_q == 2'd0, "count without open sequence")
	`UTF_ASSERT_IMP(a_front_seen_below, clk, arst_n, exp_q != 2'd0, seen_q < exp_q, "sequence overrun")

endmodule

// ===== hdl/utfdec_back.sv =====
// decoder back: expands one descriptor into code units, one word per cycle while pop frees the output
// depends on utfdec_pkg and utf8_to_utf16_decoder_core_macros.svh
`include "utf8_to_utf16_decoder_core_macros.svh"
module utfdec_back (
	input  logic                clk,
	input  logic                arst_n,
	input  utfdec_pkg::desc_t   head,
	input  logic                head_valid,
	output logic                head_pop,
	input  logic                pop,
	output logic                empty,
	output utfdec_pkg::result_t result
);

	logic [1:0]          idx_q;
	utfdec_pkg::result_t res_q;
	logic                res_valid_q;

	logic                advance;
	logic                take;
	logic [2:0]          tail_cnt;
	logic [2:0]          total;
	logic                last;
	logic [1:0]          tail_idx;
	utfdec_pkg::result_t res_d;

	assign advance = !res_valid_q || pop;
	assign take    = head_valid && advance;

	always_comb begin
		unique case (head.tail)
			utfdec_pkg::TAIL_NONE: tail_cnt = 3'd0;
			utfdec_pkg::TAIL_PAIR: tail_cnt = 3'd2;
			default:               tail_cnt = 3'd1;
		endcase
	end

	assign total    = {1'b0, head.n_repl} + tail_cnt;
	assign last     = ({1'b0, idx_q} + 3'd1) == total;
	assign tail_idx = idx_q - head.n_repl;

	always_comb begin
		res_d.code_unit  = utfdec_pkg::REPL_UNIT;
		res_d.unit_valid = 1'b1;
		res_d.text_done  = 1'b0;
		res_d.run_last   = last;
		if (idx_q >= head.n_repl) begin
			unique case (head.tail)
				utfdec_pkg::TAIL_UNIT: res_d.code_unit = head.unit_a;
				utfdec_pkg::TAIL_PAIR: begin
					res_d.code_unit = (tail_idx == 2'd0) ? head.unit_a : head.unit_b;
				end
				utfdec_pkg::TAIL_END: begin
					res_d.code_unit  = 16'd0;
					res_d.unit_valid = 1'b0;
					res_d.text_done  = 1'b1;
				end
				default: res_d.code_unit = utfdec_pkg::REPL_UNIT;
			endcase
		end
	end

	assign head_pop = take && last;
	assign empty    = !res_valid_q;
	assign result   = res_q;

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				res_valid_q <= 1'b1;
				idx_q       <= last ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	`UTF_ASSERT_IMP(a_back_idx_home, clk, arst_n, !head_valid, idx_q == 2'd0, "index left open")
	`UTF_ASSERT_IMP(a_back_order_nonempty, clk, arst_n, head_valid, total != 3'd0, "empty descriptor")

endmodule

// ===== hdl/utf8_to_utf16_decoder_core.sv =====
// utf-8 to utf-16 decoder, top level
// the input side takes one byte (or end of text) on push while full is low.
// the result side is a queue: while empty is low the oldest word is on
// result, and pop takes it. run_last marks the last word of an input item,
// text_done the bare end marker that closes a text.
// the front classifies a byte in the cycle it is accepted and writes a
// descriptor into a DESC_DEPTH-entry queue; items that yield no word write nothing.
// the back expands one descriptor into one to four words into a single output
// register that refills in the cycle its word is popped.
// an item's descriptor is registered in the queue and its words in the output
// register. throughput: one byte per cycle while full is low, one word per
// cycle while pop frees the output; an item holds the back until its last word.
// reset clears the open sequence and empties both queues.
// with pop low the output word holds, the back stops, and full rises once
// DESC_DEPTH descriptors are waiting.
// depends on utfdec_pkg, utfdec_fifo, utfdec_front, utfdec_back
module utf8_to_utf16_decoder_core #(
	parameter int DESC_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  utfdec_pkg::item_t   item,
	output logic                empty,
	input  logic                pop,
	output utfdec_pkg::result_t result
);

	localparam int DW = $bits(utfdec_pkg::desc_t);

	logic              take;
	utfdec_pkg::desc_t front_desc;
	logic              front_valid;
	utfdec_pkg::desc_t head;
	logic [DW-1:0]     head_bits;
	logic              head_empty;
	logic              head_pop;

	assign take = push && !full;
	assign head = utfdec_pkg::desc_t'(head_bits);

	utfdec_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.item       (item),
		.desc       (front_desc),
		.desc_valid (front_valid)
	);

	utfdec_fifo #(
		.WIDTH (DW),
		.DEPTH (DESC_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (take && front_valid),
		.wr_data (DW'(front_desc)),
		.rd_en   (head_pop),
		.rd_data (head_bits),
		.full    (full),
		.empty   (head_empty)
	);

	utfdec_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!head_empty),
		.head_pop   (head_pop),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

endmodule

// ===== dv/utfdec_checker.sv =====
`timescale 1ns / 1ps
// checker for the utf-8 to utf-16 decoder: predicts the words each accepted
// byte causes and compares them in order with the words popped from the block
// depends on utfdec_pkg
module utfdec_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                full,
	input  utfdec_pkg::item_t   item,
	input  logic                empty,
	input  logic                pop,
	input  utfdec_pkg::result_t result,
	output int                  fail_count,
	output int                  pending
);
	import utfdec_pkg::*;

	localparam int REPORT_MAX = 10;

	// open multi-byte sequence
	logic [1:0]  conts_needed;
	logic [1:0]  conts_taken;
	logic [20:0] cp_acc;

	result_t item_words[$];
	result_t expected_words[$];

	function automatic void add_word(logic [15:0] unit, logic valid, logic done);
		result_t w;
		w.code_unit  = unit;
		w.unit_valid = valid;
		w.text_done  = done;
		w.run_last   = 1'b0;
		item_words.push_back(w);
	endfunction

	function automatic void drop_sequence();
		conts_needed = 2'd0;
		conts_taken  = 2'd0;
		cp_acc       = '0;
	endfunction

	// one replacement for the lead and one per continuation held
	function automatic void flush_sequence();
		int i;
		if (conts_needed != 2'd0) begin
			for (i = 0; i <= conts_taken; i++)
				add_word(REPL_UNIT, 1'b1, 1'b0);
			drop_sequence();
		end
	endfunction

	function automatic void start_byte(logic [7:0] b);
		if (b[7] == 1'b0) begin
			add_word({8'd0, b}, 1'b1, 1'b0);
		end else if (b[7:5] == 3'b110) begin
			conts_needed = 2'd1;
			conts_taken  = 2'd0;
			cp_acc       = {16'd0, b[4:0]};
		end else if (b[7:4] == 4'b1110) begin
			conts_needed = 2'd2;
			conts_taken  = 2'd0;
			cp_acc       = {17'd0, b[3:0]};
		end else if (b[7:3] == 5'b11110) begin
			conts_needed = 2'd3;
			conts_taken  = 2'd0;
			cp_acc       = {18'd0, b[2:0]};
		end else begin
			// stray continuation or invalid lead
			add_word(REPL_UNIT, 1'b1, 1'b0);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [20:0] cp;
		logic [20:0] offs;
		result_t     w;
		if (!arst_n) begin
			drop_sequence();
			item_words.delete();
			expected_words.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (push && !full) begin
				item_words.delete();
				if (item.text_end) begin
					flush_sequence();
					drop_sequence();
					add_word(16'd0, 1'b0, 1'b1);
				end else if (conts_needed != 2'd0) begin
					if (item.text_byte[7:6] == 2'b10) begin
						cp = {cp_acc[14:0], item.text_byte[5:0]};
						if (conts_taken + 2'd1 >= conts_needed) begin
							drop_sequence();
							offs = cp - SUPP_BASE;
							if (cp > CP_MAX || (cp >= SURR_MIN && cp <= SURR_MAX)) begin
								add_word(REPL_UNIT, 1'b1, 1'b0);
							end else if (cp >= SUPP_BASE) begin
								add_word(HI_SURR + {6'd0, offs[19:10]}, 1'b1, 1'b0);
								add_word(LO_SURR + {6'd0, offs[9:0]}, 1'b1, 1'b0);
							end else begin
								add_word(cp[15:0], 1'b1, 1'b0);
							end
						end else begin
							cp_acc      = cp;
							conts_taken = conts_taken + 2'd1;
						end
					end else begin
						// broken sequence, then the byte starts afresh
						flush_sequence();
						start_byte(item.text_byte);
					end
				end else begin
					start_byte(item.text_byte);
				end
				if (item_words.size() > 0) begin
					w = item_words.pop_back();
					w.run_last = 1'b1;
					item_words.push_back(w);
				end
				while (item_words.size() > 0)
					expected_words.push_back(item_words.pop_front());
			end

			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("unexpected word: unit %h valid %b done %b last %b",
							result.code_unit, result.unit_valid, result.text_done,
							result.run_last);
				end else begin
					w = expected_words.pop_front();
					if (result.code_unit !== w.code_unit || result.unit_valid !== w.unit_valid ||
						result.text_done !== w.text_done || result.run_last !== w.run_last) begin
						fail_count++;
						if (fail_count <= REPORT_MAX)
							$display("word mismatch: expected unit %h valid %b done %b last %b, got unit %h valid %b done %b last %b",
								w.code_unit, w.unit_valid, w.text_done, w.run_last,
								result.code_unit, result.unit_valid, result.text_done,
								result.run_last);
					end
				end
			end
			pending = expected_words.size();
		end
	end

endmodule

// ===== dv/tb_utf8_to_utf16_decoder_core.sv =====
`timescale 1ns / 1ps
// testbench top for the utf-8 to utf-16 decoder: drives bytes and end-of-text
// items with random gaps and pop stalls, verdict from utfdec_checker
// depends on utfdec_pkg, utfdec_checker and the decoder rtl
module tb_utf8_to_utf16_decoder_core;
	import utfdec_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 385;
	localparam int N_DIRECTED   = 27;

	// bit 8 set marks end of text
	localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
		9'h000, 9'h07F,
		9'h0E2, 9'h082, 9'h0AC,
		9'h0F0, 9'h09F, 9'h098, 9'h080,
		9'h0FF, 9'h080,
		9'h0C0, 9'h080,
		9'h0ED, 9'h0A0, 9'h080,
		9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
		9'h0F0, 9'h09F, 9'h041,
		9'h0E1, 9'h080, 9'h1A5,
		9'h15A
	};

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    push   = 1'b0;
	logic    pop    = 1'b0;
	item_t   item   = '0;
	logic    full;
	logic    empty;
	result_t result;
	int      fail_count;
	int      pending;

	int burst_left  = 0;
	int items_sent  = 0;
	int idle_cycles = 0;
	int pop_mode    = 0;
	int mode_left   = 0;
	int stall_left  = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	utf8_to_utf16_decoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	utfdec_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// receiver: free-running, random, sparse and long-stall phases
	always @(negedge clk) begin
		if (mode_left == 0) begin
			pop_mode  <= $urandom_range(0, 3);
			mode_left <= $urandom_range(32, 255);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (pop_mode)
			0: pop <= 1'b1;
			1: pop <= 1'($urandom_range(0, 1));
			2: pop <= ($urandom_range(0, 3) == 0);
			default: begin
				if (stall_left == 0) begin
					stall_left <= $urandom_range(1, 15);
					pop <= 1'b1;
				end else begin
					stall_left <= stall_left - 1;
					pop <= 1'b0;
				end
			end
		endcase
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input logic [7:0] b, input logic e);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		item <= '{text_byte: b, text_end: e};
		push <= 1'b1;
		do @(posedge clk); while (full);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_sequence(input int len, input int conts);
		logic [7:0] lead;
		lead = 8'($urandom);
		case (len)
			1: lead[7] = 1'b0;
			2: lead[7:5] = 3'b110;
			3: lead[7:4] = 4'b1110;
			default: lead[7:3] = 5'b11110;
		endcase
		send_item(lead, 1'b0);
		repeat (conts) send_item({2'b10, 6'($urandom)}, 1'b0);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (pending != 0);
	endtask

	initial begin
		int pick;
		int len;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i])
			send_item(DIRECTED[i][7:0], DIRECTED[i][8]);
		wait_drained();

		// mostly well-formed sequences with random payload bits
		while (items_sent < N_DIRECTED + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				send_item(8'($urandom), 1'b1);
			end else if (pick < 14) begin
				send_item(8'($urandom), 1'b0);
			end else if (pick < 24) begin
				len = $urandom_range(2, 4);
				send_sequence(len, $urandom_range(0, len - 2));
			end else begin
				len = $urandom_range(1, 4);
				send_sequence(len, len - 1);
			end
			if ($urandom_range(0, 99) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
